/* src/bds_pkg.sv */
// ============================================================================
// bds_pkg - shared types and constants of the baseline deviation scorer
// Field widths, operation and register codes, reset values and the state
// types of the control sequencer, the quantity lanes and the merge stage.
// ============================================================================
package bds_pkg;

    // Field widths
    localparam int OP_W     = 2;
    localparam int HR_W     = 12;
    localparam int HRV_W    = 13;
    localparam int TEMP_W   = 14;
    localparam int DAY_W    = 32;
    localparam int SCORE_W  = 7;
    localparam int MIN_W    = 16;
    localparam int WEIGHT_W = 8;
    localparam int FS_W     = 8;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;

    // Deviation format: Q13.16 with saturation at 8192 SD
    localparam int DEV_INT_BITS  = 13;
    localparam int DEV_FRAC_BITS = 16;
    localparam int DEV_W         = DEV_INT_BITS + DEV_FRAC_BITS + 1;
    localparam logic [DEV_W-1:0] DEV_SAT = {1'b1, {(DEV_W-1){1'b0}}};

    localparam logic [SCORE_W-1:0] SCORE_MAX = 7'd100;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_DAY   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Register indexes
    localparam logic [2:0] REG_MIN_SAMPLES = 3'd0;
    localparam logic [2:0] REG_HR_FLOOR    = 3'd1;
    localparam logic [2:0] REG_HRV_FLOOR   = 3'd2;
    localparam logic [2:0] REG_TEMP_FLOOR  = 3'd3;
    localparam logic [2:0] REG_HR_WEIGHT   = 3'd4;
    localparam logic [2:0] REG_HRV_WEIGHT  = 3'd5;
    localparam logic [2:0] REG_TEMP_WEIGHT = 3'd6;
    localparam logic [2:0] REG_FULL_SCALE  = 3'd7;

    // Register reset values
    localparam logic [MIN_W-1:0]    RST_MIN_SAMPLES = 16'd20;
    localparam logic [HR_W-1:0]     RST_HR_FLOOR    = 12'd40;
    localparam logic [HRV_W-1:0]    RST_HRV_FLOOR   = 13'd64;
    localparam logic [TEMP_W-1:0]   RST_TEMP_FLOOR  = 14'd64;
    localparam logic [WEIGHT_W-1:0] RST_HR_WEIGHT   = 8'd77;
    localparam logic [WEIGHT_W-1:0] RST_HRV_WEIGHT  = 8'd115;
    localparam logic [WEIGHT_W-1:0] RST_TEMP_WEIGHT = 8'd64;
    localparam logic [FS_W-1:0]     RST_FULL_SCALE  = 8'd32;

    // Commands from the sequencer to every lane
    typedef struct packed {
        logic start_mean;
        logic start_dev;
        logic ent_valid;
        logic ent_last;
    } lane_cmd_t;

    typedef enum logic [2:0] {
        T_IDLE,
        T_MEAN,
        T_EVAL,
        T_SWEEP,
        T_DEV,
        T_MERGE,
        T_FIN
    } top_state_t;

    typedef enum logic [3:0] {
        L_IDLE,
        L_ACC,
        L_VAR1,
        L_VAR2,
        L_SQRT,
        L_NUM,
        L_DEN,
        L_SAT,
        L_DIV,
        L_DONE
    } lane_state_t;

    typedef enum logic [2:0] {
        M_IDLE,
        M_MUL,
        M_SUM,
        M_PREP,
        M_DIV,
        M_DONE
    } merge_state_t;

endpackage

/* src/bds_lane.sv */
// ============================================================================
// bds_lane - one vital-sign quantity
// Rounded daily mean by restoring division, or the deviation of today from
// the baseline ring: sum and sum of squares over the streamed ring entries,
// bit-serial square root, then a 29-step Q13.16 division with saturation.
// ============================================================================
module bds_lane #(
    parameter int VAL_W         = 12,
    parameter int COUNT_BITS    = 20,
    parameter int BASELINE_DAYS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bds_pkg::lane_cmd_t            cmd,
    input  logic [COUNT_BITS+VAL_W-1:0]   sum,
    input  logic [COUNT_BITS-1:0]         count,
    input  logic [VAL_W-1:0]              sd_floor,
    input  logic [VAL_W-1:0]              entry,
    output logic                          done,
    output logic [VAL_W-1:0]              mean,
    output logic [bds_pkg::DEV_W-1:0]     dev
);
    import bds_pkg::*;

    localparam int NB    = $clog2(BASELINE_DAYS + 1);
    localparam int SUM_W = COUNT_BITS + VAL_W;
    localparam int S_W   = VAL_W + NB;
    localparam int Q_W   = 2 * VAL_W + NB;
    localparam int VAR_W = 2 * VAL_W + 2 * NB;
    localparam int R_W   = VAL_W + NB;
    localparam int NUM_W = SUM_W + NB;
    localparam int DEN_W = COUNT_BITS + R_W;
    localparam int QB    = DEV_INT_BITS + DEV_FRAC_BITS;
    localparam int SAT_W = DEN_W + DEV_INT_BITS;
    localparam logic [NB-1:0] N_DAYS = NB'(BASELINE_DAYS);

    lane_state_t        state_reg, state_next;
    logic [S_W-1:0]     s_reg;
    logic [Q_W-1:0]     q_reg;
    logic [VAR_W-1:0]   a_reg, b_reg;
    logic [VAR_W-1:0]   v_reg, r_reg, bit_reg;
    logic [R_W-1:0]     sdn_reg;
    logic [NUM_W-1:0]   na_reg, nb_reg, num_reg;
    logic [DEN_W-1:0]   den_reg, rem_reg;
    logic [QB-1:0]      ds_reg, quot_reg;
    logic [4:0]         step_reg;
    logic               sat_reg;

    logic [SUM_W:0]     mean_x;
    logic [VAR_W:0]     sq_try;
    logic [DEN_W:0]     div_t;
    logic               div_ge;
    logic [VAL_W-1:0]   floor_eff;
    logic [R_W-1:0]     floor_n;
    logic               job_start;

    assign job_start = cmd.start_mean | cmd.start_dev;
    assign mean_x    = (SUM_W+1)'(sum) + (SUM_W+1)'(count >> 1);
    assign sq_try    = (VAR_W+1)'(r_reg) + (VAR_W+1)'(bit_reg);
    assign div_t     = {rem_reg, ds_reg[QB-1]};
    assign div_ge    = div_t >= {1'b0, den_reg};
    assign floor_eff = (sd_floor == '0) ? VAL_W'(1) : sd_floor;
    assign floor_n   = R_W'(floor_eff) * R_W'(N_DAYS);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            L_IDLE, L_DONE:
            begin
                if (cmd.start_mean)
                    state_next = L_DIV;
                else if (cmd.start_dev)
                    state_next = L_ACC;
            end
            L_ACC:  if (cmd.ent_valid && cmd.ent_last) state_next = L_VAR1;
            L_VAR1: state_next = L_VAR2;
            L_VAR2: state_next = L_SQRT;
            L_SQRT: if (bit_reg == '0) state_next = L_NUM;
            L_NUM:  state_next = L_DEN;
            L_DEN:  state_next = L_SAT;
            L_SAT:  state_next = L_DIV;
            L_DIV:  if (step_reg == 5'd1) state_next = L_DONE;
            default: state_next = L_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        done = (state_reg == L_DONE);
        mean = quot_reg[VAL_W-1:0];
        dev  = sat_reg ? DEV_SAT : {1'b0, quot_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= L_IDLE;
        else
            state_reg <= state_next;
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            L_IDLE, L_DONE:
            begin
                if (cmd.start_mean)
                begin
                    // load the rounded-mean division
                    rem_reg  <= DEN_W'(mean_x >> VAL_W);
                    ds_reg   <= {mean_x[VAL_W-1:0], {(QB-VAL_W){1'b0}}};
                    den_reg  <= DEN_W'(count);
                    quot_reg <= '0;
                    step_reg <= 5'(VAL_W);
                    sat_reg  <= 1'b0;
                end
                else if (job_start)
                begin
                    s_reg <= '0;
                    q_reg <= '0;
                end
            end
            L_ACC:
            begin
                // accumulate sum and sum of squares of the ring
                if (cmd.ent_valid)
                begin
                    s_reg <= s_reg + S_W'(entry);
                    q_reg <= q_reg + Q_W'(entry) * Q_W'(entry);
                end
            end
            L_VAR1:
            begin
                a_reg <= VAR_W'(q_reg) * VAR_W'(N_DAYS);
                b_reg <= VAR_W'(s_reg) * VAR_W'(s_reg);
            end
            L_VAR2:
            begin
                v_reg   <= (a_reg > b_reg) ? a_reg - b_reg : '0;
                r_reg   <= '0;
                bit_reg <= {2'b01, {(VAR_W-2){1'b0}}};
            end
            L_SQRT:
            begin
                // one result bit per cycle
                if (bit_reg != '0)
                begin
                    if ((VAR_W+1)'(v_reg) >= sq_try)
                    begin
                        v_reg <= v_reg - VAR_W'(sq_try);
                        r_reg <= (r_reg >> 1) + bit_reg;
                    end
                    else
                        r_reg <= r_reg >> 1;
                    bit_reg <= bit_reg >> 2;
                end
            end
            L_NUM:
            begin
                sdn_reg <= (r_reg[R_W-1:0] < floor_n) ? floor_n : r_reg[R_W-1:0];
                na_reg  <= NUM_W'(sum) * NUM_W'(N_DAYS);
                nb_reg  <= NUM_W'(s_reg) * NUM_W'(count);
            end
            L_DEN:
            begin
                num_reg <= (na_reg > nb_reg) ? na_reg - nb_reg : nb_reg - na_reg;
                den_reg <= DEN_W'(count) * DEN_W'(sdn_reg);
            end
            L_SAT:
            begin
                // quotient at or above 8192 saturates, otherwise 29 bits remain
                sat_reg  <= SAT_W'(num_reg) >= {den_reg, {DEV_INT_BITS{1'b0}}};
                rem_reg  <= DEN_W'(num_reg >> DEV_INT_BITS);
                ds_reg   <= {num_reg[DEV_INT_BITS-1:0], {DEV_FRAC_BITS{1'b0}}};
                quot_reg <= '0;
                step_reg <= 5'(QB);
            end
            L_DIV:
            begin
                rem_reg  <= div_ge ? DEN_W'(div_t - {1'b0, den_reg}) : DEN_W'(div_t);
                quot_reg <= {quot_reg[QB-2:0], div_ge};
                ds_reg   <= ds_reg << 1;
                step_reg <= step_reg - 5'd1;
            end
            default: ;
        endcase
    end

endmodule

/* src/bds_merge.sv */
// ============================================================================
// bds_merge - combine lane deviations into the score
// Weighted sum of the three deviations, rounding and scaling by full scale,
// then a 7-step division that caps the score at 100.
// ============================================================================
module bds_merge (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [bds_pkg::DEV_W-1:0]        hr_dev,
    input  logic [bds_pkg::DEV_W-1:0]        hrv_dev,
    input  logic [bds_pkg::DEV_W-1:0]        temp_dev,
    input  logic [bds_pkg::WEIGHT_W-1:0]     hr_weight,
    input  logic [bds_pkg::WEIGHT_W-1:0]     hrv_weight,
    input  logic [bds_pkg::WEIGHT_W-1:0]     temp_weight,
    input  logic [bds_pkg::FS_W-1:0]         full_scale,
    output logic                             done,
    output logic [bds_pkg::SCORE_W-1:0]      score
);
    import bds_pkg::*;

    localparam int P_W   = WEIGHT_W + DEV_W;
    localparam int ACC_W = P_W + 2;
    localparam int X_W   = ACC_W + 8;
    localparam int Y_W   = X_W - 20;

    merge_state_t        state_reg, state_next;
    logic [P_W-1:0]      p0_reg, p1_reg, p2_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic [FS_W-1:0]     rem_reg;
    logic [SCORE_W-1:0]  ds_reg, quot_reg;
    logic [2:0]          step_reg;
    logic                sat_reg;

    logic [FS_W-1:0]     fs_eff;
    logic [X_W-1:0]      acc_x, scaled;
    logic [Y_W-1:0]      y;
    logic [FS_W:0]       div_t;
    logic                div_ge;

    assign fs_eff = (full_scale == '0) ? FS_W'(1) : full_scale;
    assign acc_x  = X_W'(acc_reg);
    // 100 * acc plus half of full_scale * 2^20, then drop 20 bits
    assign scaled = (acc_x << 6) + (acc_x << 5) + (acc_x << 2) + X_W'({fs_eff, 19'b0});
    assign y      = scaled[X_W-1:20];
    assign div_t  = {rem_reg, ds_reg[SCORE_W-1]};
    assign div_ge = div_t >= {1'b0, fs_eff};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            M_IDLE, M_DONE: if (start) state_next = M_MUL;
            M_MUL:  state_next = M_SUM;
            M_SUM:  state_next = M_PREP;
            M_PREP: state_next = M_DIV;
            M_DIV:  if (step_reg == 3'd1) state_next = M_DONE;
            default: state_next = M_IDLE;
        endcase
    end

    always_comb
    begin
        done  = (state_reg == M_DONE);
        score = (sat_reg || quot_reg > SCORE_MAX) ? SCORE_MAX : quot_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= M_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            M_MUL:
            begin
                p0_reg <= P_W'(hr_weight) * P_W'(hr_dev);
                p1_reg <= P_W'(hrv_weight) * P_W'(hrv_dev);
                p2_reg <= P_W'(temp_weight) * P_W'(temp_dev);
            end
            M_SUM:
                acc_reg <= ACC_W'(p0_reg) + ACC_W'(p1_reg) + ACC_W'(p2_reg);
            M_PREP:
            begin
                // 128 full scales or more is past the cap
                sat_reg  <= y >= Y_W'({fs_eff, 7'b0});
                rem_reg  <= y[FS_W+SCORE_W-1:SCORE_W];
                ds_reg   <= y[SCORE_W-1:0];
                quot_reg <= '0;
                step_reg <= 3'(SCORE_W);
            end
            M_DIV:
            begin
                rem_reg  <= div_ge ? FS_W'(div_t - {1'b0, fs_eff}) : FS_W'(div_t);
                quot_reg <= {quot_reg[SCORE_W-2:0], div_ge};
                ds_reg   <= ds_reg << 1;
                step_reg <= step_reg - 3'd1;
            end
            default: ;
        endcase
    end

endmodule

/* src/baseline_deviation_scorer_core.sv */
// ============================================================================
// baseline_deviation_scorer_core - vital-sign deviation scorer
// Daily sums, a ring of daily baselines and a score against that baseline,
// computed by three quantity lanes and a merge stage.
//
//   channel   direction  handshake                 payload
//   in        request in in_valid / in_ready       operation, heart_rate,
//                                                   hrv_value, skin_temp,
//                                                   day_number
//   out       result out out_valid / out_ready     score, days_collected,
//                                                   baseline_ready
//   config    APB write  psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One request at a time. Any request that finds the ring full and samples in
// today's sums runs the ring sweep, the lane square root, the 29-step lane
// divider and the 7-step score divider. A day roll that stores a day runs
// the rounded-mean divider; other requests run neither divider.
// Reset clears all state; the ring needs no clearing since it is read only
// once all of it is written. A waiting result does not block the next request;
// a second finished result holds the sequencer until the first is taken.
// ============================================================================
module baseline_deviation_scorer_core #(
    parameter int BASELINE_DAYS = 16,
    parameter int COUNT_BITS    = 20
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bds_pkg::PADDR_W-1:0]         paddr,
    input  logic [bds_pkg::PDATA_W-1:0]         pwdata,
    output logic [bds_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [bds_pkg::OP_W-1:0]            operation,
    input  logic [bds_pkg::HR_W-1:0]            heart_rate,
    input  logic [bds_pkg::HRV_W-1:0]           hrv_value,
    input  logic [bds_pkg::TEMP_W-1:0]          skin_temp,
    input  logic [bds_pkg::DAY_W-1:0]           day_number,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [bds_pkg::SCORE_W-1:0]         score,
    output logic [$clog2(BASELINE_DAYS+1)-1:0]  days_collected,
    output logic                                baseline_ready
);
    import bds_pkg::*;

    localparam int ADDR_W   = $clog2(BASELINE_DAYS);
    localparam int FILL_W   = $clog2(BASELINE_DAYS + 1);
    localparam int ENT_W    = HR_W + HRV_W + TEMP_W;
    localparam int CMP_W    = (COUNT_BITS > MIN_W) ? COUNT_BITS : MIN_W;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(BASELINE_DAYS - 1);
    localparam logic [FILL_W-1:0] FULL     = FILL_W'(BASELINE_DAYS);

    // Configuration registers
    logic [MIN_W-1:0]    min_samples_reg;
    logic [HR_W-1:0]     hr_floor_reg;
    logic [HRV_W-1:0]    hrv_floor_reg;
    logic [TEMP_W-1:0]   temp_floor_reg;
    logic [WEIGHT_W-1:0] hr_weight_reg, hrv_weight_reg, temp_weight_reg;
    logic [FS_W-1:0]     full_scale_reg;

    // Block state
    top_state_t                  state_reg, state_next;
    logic [COUNT_BITS+HR_W-1:0]  sum_hr_reg;
    logic [COUNT_BITS+HRV_W-1:0] sum_hrv_reg;
    logic [COUNT_BITS+TEMP_W-1:0] sum_temp_reg;
    logic [COUNT_BITS-1:0]       count_reg;
    logic [DAY_W-1:0]            current_day_reg;
    logic [ADDR_W-1:0]           slot_reg, addr_reg;
    logic [FILL_W-1:0]           filled_reg;
    logic                        ent_valid_reg, ent_last_reg;
    logic [ENT_W-1:0]            rd_data_reg;
    logic [ENT_W-1:0]            ring_mem [BASELINE_DAYS];
    logic [SCORE_W-1:0]          result_reg;

    // Output register
    logic                        out_valid_reg;
    logic [SCORE_W-1:0]          out_score_reg;
    logic [FILL_W-1:0]           out_days_reg;
    logic                        out_full_reg;

    logic                        cfg_write, in_acc, count_full, count_ge, day_roll;
    logic                        eval_go, lanes_done, merge_start, merge_done, out_load;
    logic [MIN_W-1:0]            need;
    lane_cmd_t                   lane_cmd;
    logic                        hr_done, hrv_done, temp_done;
    logic [HR_W-1:0]             hr_mean;
    logic [HRV_W-1:0]            hrv_mean;
    logic [TEMP_W-1:0]           temp_mean;
    logic [DEV_W-1:0]            hr_dev, hrv_dev, temp_dev;
    logic [SCORE_W-1:0]          merge_score;

    assign pready     = 1'b1;
    assign cfg_write  = psel && penable && pwrite && pready;
    assign in_acc     = in_valid && in_ready;
    assign count_full = &count_reg;
    assign need       = (min_samples_reg == '0) ? MIN_W'(1) : min_samples_reg;
    assign count_ge   = CMP_W'(count_reg) >= CMP_W'(need);
    assign day_roll   = (day_number != current_day_reg);
    assign eval_go    = (filled_reg == FULL) && (count_reg != '0);
    assign lanes_done = hr_done && hrv_done && temp_done;
    assign out_load   = (state_reg == T_FIN) && (!out_valid_reg || out_ready);

    // Configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_samples_reg <= RST_MIN_SAMPLES;
            hr_floor_reg    <= RST_HR_FLOOR;
            hrv_floor_reg   <= RST_HRV_FLOOR;
            temp_floor_reg  <= RST_TEMP_FLOOR;
            hr_weight_reg   <= RST_HR_WEIGHT;
            hrv_weight_reg  <= RST_HRV_WEIGHT;
            temp_weight_reg <= RST_TEMP_WEIGHT;
            full_scale_reg  <= RST_FULL_SCALE;
        end
        else if (cfg_write)
        begin
            unique case (paddr[4:2])
                REG_MIN_SAMPLES: min_samples_reg <= pwdata[MIN_W-1:0];
                REG_HR_FLOOR:    hr_floor_reg    <= pwdata[HR_W-1:0];
                REG_HRV_FLOOR:   hrv_floor_reg   <= pwdata[HRV_W-1:0];
                REG_TEMP_FLOOR:  temp_floor_reg  <= pwdata[TEMP_W-1:0];
                REG_HR_WEIGHT:   hr_weight_reg   <= pwdata[WEIGHT_W-1:0];
                REG_HRV_WEIGHT:  hrv_weight_reg  <= pwdata[WEIGHT_W-1:0];
                REG_TEMP_WEIGHT: temp_weight_reg <= pwdata[WEIGHT_W-1:0];
                REG_FULL_SCALE:  full_scale_reg  <= pwdata[FS_W-1:0];
                default: ;
            endcase
        end
    end

    // Configuration read
    always_comb
    begin
        unique case (paddr[4:2])
            REG_MIN_SAMPLES: prdata = PDATA_W'(min_samples_reg);
            REG_HR_FLOOR:    prdata = PDATA_W'(hr_floor_reg);
            REG_HRV_FLOOR:   prdata = PDATA_W'(hrv_floor_reg);
            REG_TEMP_FLOOR:  prdata = PDATA_W'(temp_floor_reg);
            REG_HR_WEIGHT:   prdata = PDATA_W'(hr_weight_reg);
            REG_HRV_WEIGHT:  prdata = PDATA_W'(hrv_weight_reg);
            REG_TEMP_WEIGHT: prdata = PDATA_W'(temp_weight_reg);
            REG_FULL_SCALE:  prdata = PDATA_W'(full_scale_reg);
            default:         prdata = '0;
        endcase
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            T_IDLE:
            begin
                if (in_acc)
                begin
                    if (operation == OP_DAY && day_roll && count_ge)
                        state_next = T_MEAN;
                    else
                        state_next = T_EVAL;
                end
            end
            T_MEAN:  if (lanes_done) state_next = T_EVAL;
            T_EVAL:  state_next = eval_go ? T_SWEEP : T_FIN;
            T_SWEEP: if (addr_reg == LAST_ADDR) state_next = T_DEV;
            T_DEV:   if (lanes_done) state_next = T_MERGE;
            T_MERGE: if (merge_done) state_next = T_FIN;
            T_FIN:   if (out_load) state_next = T_IDLE;
            default: state_next = T_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        in_ready            = (state_reg == T_IDLE);
        lane_cmd.start_mean = (state_reg == T_IDLE) && in_acc && operation == OP_DAY
                              && day_roll && count_ge;
        lane_cmd.start_dev  = (state_reg == T_EVAL) && eval_go;
        lane_cmd.ent_valid  = ent_valid_reg;
        lane_cmd.ent_last   = ent_last_reg;
        merge_start         = (state_reg == T_DEV) && lanes_done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= T_IDLE;
        else
            state_reg <= state_next;
    end

    // Daily sums, day tracking and ring pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_hr_reg      <= '0;
            sum_hrv_reg     <= '0;
            sum_temp_reg    <= '0;
            count_reg       <= '0;
            current_day_reg <= '0;
            slot_reg        <= '0;
            filled_reg      <= '0;
        end
        else if (state_reg == T_IDLE && in_acc)
        begin
            unique case (operation)
                OP_ADD:
                begin
                    // drop samples once the counter is full
                    if (!count_full)
                    begin
                        sum_hr_reg   <= sum_hr_reg + ($bits(sum_hr_reg))'(heart_rate);
                        sum_hrv_reg  <= sum_hrv_reg + ($bits(sum_hrv_reg))'(hrv_value);
                        sum_temp_reg <= sum_temp_reg + ($bits(sum_temp_reg))'(skin_temp);
                        count_reg    <= count_reg + 1'b1;
                    end
                end
                OP_DAY:
                begin
                    if (day_roll)
                    begin
                        current_day_reg <= day_number;
                        // a short day is dropped here, a full one after its means
                        if (!count_ge)
                        begin
                            sum_hr_reg   <= '0;
                            sum_hrv_reg  <= '0;
                            sum_temp_reg <= '0;
                            count_reg    <= '0;
                        end
                    end
                end
                OP_CLEAR:
                begin
                    sum_hr_reg      <= '0;
                    sum_hrv_reg     <= '0;
                    sum_temp_reg    <= '0;
                    count_reg       <= '0;
                    current_day_reg <= '0;
                    slot_reg        <= '0;
                    filled_reg      <= '0;
                end
                default: ;
            endcase
        end
        else if (state_reg == T_MEAN && lanes_done)
        begin
            // advance the ring after storing the day
            slot_reg     <= (slot_reg == LAST_ADDR) ? '0 : slot_reg + 1'b1;
            filled_reg   <= (filled_reg == FULL) ? filled_reg : filled_reg + 1'b1;
            sum_hr_reg   <= '0;
            sum_hrv_reg  <= '0;
            sum_temp_reg <= '0;
            count_reg    <= '0;
        end
    end

    // Ring memory
    always_ff @(posedge clk)
    begin
        if (state_reg == T_MEAN && lanes_done)
            ring_mem[slot_reg] <= {hr_mean, hrv_mean, temp_mean};
        rd_data_reg <= ring_mem[addr_reg];
    end

    // Ring sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg      <= '0;
            ent_valid_reg <= 1'b0;
            ent_last_reg  <= 1'b0;
        end
        else
        begin
            ent_valid_reg <= (state_reg == T_SWEEP);
            ent_last_reg  <= (state_reg == T_SWEEP) && (addr_reg == LAST_ADDR);
            if (state_reg == T_EVAL)
                addr_reg <= '0;
            else if (state_reg == T_SWEEP && addr_reg != LAST_ADDR)
                addr_reg <= addr_reg + 1'b1;
        end
    end

    // Hold the score of this request
    always_ff @(posedge clk)
    begin
        if (state_reg == T_EVAL && !eval_go)
            result_reg <= '0;
        else if (state_reg == T_MERGE && merge_done)
            result_reg <= merge_score;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_score_reg <= result_reg;
            out_days_reg  <= filled_reg;
            out_full_reg  <= (filled_reg == FULL);
        end
    end

    assign out_valid      = out_valid_reg;
    assign score          = out_score_reg;
    assign days_collected = out_days_reg;
    assign baseline_ready = out_full_reg;

    bds_lane #(
        .VAL_W         (HR_W),
        .COUNT_BITS    (COUNT_BITS),
        .BASELINE_DAYS (BASELINE_DAYS)
    ) u_lane_hr (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (lane_cmd),
        .sum      (sum_hr_reg),
        .count    (count_reg),
        .sd_floor (hr_floor_reg),
        .entry    (rd_data_reg[ENT_W-1 -: HR_W]),
        .done     (hr_done),
        .mean     (hr_mean),
        .dev      (hr_dev)
    );

    bds_lane #(
        .VAL_W         (HRV_W),
        .COUNT_BITS    (COUNT_BITS),
        .BASELINE_DAYS (BASELINE_DAYS)
    ) u_lane_hrv (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (lane_cmd),
        .sum      (sum_hrv_reg),
        .count    (count_reg),
        .sd_floor (hrv_floor_reg),
        .entry    (rd_data_reg[TEMP_W +: HRV_W]),
        .done     (hrv_done),
        .mean     (hrv_mean),
        .dev      (hrv_dev)
    );

    bds_lane #(
        .VAL_W         (TEMP_W),
        .COUNT_BITS    (COUNT_BITS),
        .BASELINE_DAYS (BASELINE_DAYS)
    ) u_lane_temp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (lane_cmd),
        .sum      (sum_temp_reg),
        .count    (count_reg),
        .sd_floor (temp_floor_reg),
        .entry    (rd_data_reg[TEMP_W-1:0]),
        .done     (temp_done),
        .mean     (temp_mean),
        .dev      (temp_dev)
    );

    bds_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (merge_start),
        .hr_dev      (hr_dev),
        .hrv_dev     (hrv_dev),
        .temp_dev    (temp_dev),
        .hr_weight   (hr_weight_reg),
        .hrv_weight  (hrv_weight_reg),
        .temp_weight (temp_weight_reg),
        .full_scale  (full_scale_reg),
        .done        (merge_done),
        .score       (merge_score)
    );

endmodule

/* src/bds_checker.sv */
// ============================================================================
// bds_checker - port-level checks of the deviation scorer
// Score range, ring-full flag against the day count, zero score without a full ring, and result hold.
// ============================================================================
module bds_checker #(
    parameter int BASELINE_DAYS = 16
) (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic [bds_pkg::SCORE_W-1:0]        score,
    input logic [$clog2(BASELINE_DAYS+1)-1:0] days_collected,
    input logic                               baseline_ready
);
    import bds_pkg::*;

    localparam int FILL_W = $clog2(BASELINE_DAYS + 1);

    // Score never passes the cap
    a_score_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> score <= SCORE_MAX)
        else $error("score above 100");

    // Ready flag follows the day count
    a_ready_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> baseline_ready == (days_collected == FILL_W'(BASELINE_DAYS)))
        else $error("baseline_ready disagrees with days_collected");

    // No score before the ring is full
    a_no_score: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !baseline_ready |-> score == '0)
        else $error("score reported without a full baseline");

    // Hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(score) && $stable(days_collected))
        else $error("stalled result changed");

endmodule

bind baseline_deviation_scorer_core bds_checker #(
    .BASELINE_DAYS (BASELINE_DAYS)
) u_bds_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .score          (score),
    .days_collected (days_collected),
    .baseline_ready (baseline_ready)
);

/* test/bds_checker.sv */
// ----------------------------------------------------------------------------
// bds_scoreboard - scoreboard of the baseline deviation scorer
// Tracks register writes and accepted requests, keeps its own copy of the
// daily sums and baseline ring, predicts every result and compares each
// accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module bds_scoreboard #(
    parameter int DAYS    = 16,
    parameter int CNT_W   = 20,
    parameter int DAYS_W  = 5
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic                         pready,
    input  logic [bds_pkg::PADDR_W-1:0]  paddr,
    input  logic [bds_pkg::PDATA_W-1:0]  pwdata,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic [bds_pkg::OP_W-1:0]     operation,
    input  logic [bds_pkg::HR_W-1:0]     heart_rate,
    input  logic [bds_pkg::HRV_W-1:0]    hrv_value,
    input  logic [bds_pkg::TEMP_W-1:0]   skin_temp,
    input  logic [bds_pkg::DAY_W-1:0]    day_number,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic [bds_pkg::SCORE_W-1:0]  score,
    input  logic [DAYS_W-1:0]            days_collected,
    input  logic                         baseline_ready,
    output int                           errors,
    output int                           pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import bds_pkg::*;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [DAYS_W-1:0]  days;
        logic               ready;
    } status_t;

    localparam logic [63:0] COUNT_FULL = (64'd1 << CNT_W) - 64'd1;

    // register copies
    logic [MIN_W-1:0]    min_samples;
    logic [HR_W-1:0]     hr_floor;
    logic [HRV_W-1:0]    hrv_floor;
    logic [TEMP_W-1:0]   temp_floor;
    logic [WEIGHT_W-1:0] hr_wt, hrv_wt, temp_wt;
    logic [FS_W-1:0]     full_scale;

    // baseline ring and today's sums
    logic [HR_W-1:0]     ring_hr   [DAYS];
    logic [HRV_W-1:0]    ring_hrv  [DAYS];
    logic [TEMP_W-1:0]   ring_temp [DAYS];
    logic                ring_ok   [DAYS];
    int                  slot;
    int                  filled;
    logic [DAY_W-1:0]    today;
    logic [63:0]         acc_hr, acc_hrv, acc_temp, n_samples;

    status_t             pending_status[$];

    assign pending = pending_status.size();

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // num/den in Q.16, truncated, saturating at 8192 SD
    function automatic logic [63:0] sd_ratio(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] rem;
        q = num / den;
        rem = num % den;
        if (q >= 64'd8192) return 64'd8192 << 16;
        for (int i = 0; i < 16; i++)
        begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= den)
            begin
                rem = rem - den;
                q = q | 64'd1;
            end
        end
        return q;
    endfunction

    // deviation of one quantity; lane 0 heart rate, 1 HRV, 2 temperature
    function automatic logic [63:0] lane_deviation(input int lane, input logic [63:0] total,
                                                   input logic [63:0] flr);
        logic [63:0] n, s, sq, v, a, b, sdn, fl, num;
        n = 0; s = 0; sq = 0;
        for (int i = 0; i < DAYS; i++)
        begin
            if (ring_ok[i])
            begin
                v = (lane == 0) ? 64'(ring_hr[i]) :
                    (lane == 1) ? 64'(ring_hrv[i]) : 64'(ring_temp[i]);
                n = n + 1;
                s = s + v;
                sq = sq + v * v;
            end
        end
        if (n == 0 || n_samples == 0) return 0;
        a = n * sq;
        b = s * s;
        sdn = int_sqrt((a > b) ? a - b : 64'd0);
        fl = n * ((flr == 0) ? 64'd1 : flr);
        if (sdn < fl) sdn = fl;
        a = n * total;
        b = s * n_samples;
        num = (a > b) ? a - b : b - a;
        return sd_ratio(num, n_samples * sdn);
    endfunction

    function automatic status_t current_status();
        status_t     st;
        logic [63:0] acc, den, sc;
        st = '0;
        st.days = DAYS_W'(filled);
        st.ready = (filled >= DAYS);
        if (filled >= DAYS && n_samples != 0)
        begin
            acc = 64'(hr_wt) * lane_deviation(0, acc_hr, 64'(hr_floor))
                + 64'(hrv_wt) * lane_deviation(1, acc_hrv, 64'(hrv_floor))
                + 64'(temp_wt) * lane_deviation(2, acc_temp, 64'(temp_floor));
            den = ((full_scale == 0) ? 64'd1 : 64'(full_scale)) << 20;
            sc = (64'd100 * acc + den / 2) / den;
            st.score = (sc > 64'd100) ? SCORE_MAX : SCORE_W'(sc);
        end
        return st;
    endfunction

    task automatic clear_all();
        for (int i = 0; i < DAYS; i++)
        begin
            ring_hr[i] = '0;
            ring_hrv[i] = '0;
            ring_temp[i] = '0;
            ring_ok[i] = 1'b0;
        end
        slot = 0; filled = 0; today = '0;
        acc_hr = 0; acc_hrv = 0; acc_temp = 0; n_samples = 0;
    endtask

    // close the day; push rounded means if it had enough samples
    task automatic close_day(input logic [DAY_W-1:0] day_id);
        logic [63:0] need;
        need = (min_samples == 0) ? 64'd1 : 64'(min_samples);
        if (day_id == today) return;
        if (n_samples >= need)
        begin
            ring_hr[slot]   = HR_W'((acc_hr + n_samples / 2) / n_samples);
            ring_hrv[slot]  = HRV_W'((acc_hrv + n_samples / 2) / n_samples);
            ring_temp[slot] = TEMP_W'((acc_temp + n_samples / 2) / n_samples);
            ring_ok[slot] = 1'b1;
            slot = (slot + 1) % DAYS;
            if (filled < DAYS) filled++;
        end
        today = day_id;
        acc_hr = 0; acc_hrv = 0; acc_temp = 0; n_samples = 0;
    endtask

    always @(posedge clk)
    begin
        status_t got, want;
        if (!rst_n)
        begin
            min_samples = RST_MIN_SAMPLES;
            hr_floor = RST_HR_FLOOR;
            hrv_floor = RST_HRV_FLOOR;
            temp_floor = RST_TEMP_FLOOR;
            hr_wt = RST_HR_WEIGHT;
            hrv_wt = RST_HRV_WEIGHT;
            temp_wt = RST_TEMP_WEIGHT;
            full_scale = RST_FULL_SCALE;
            clear_all();
            pending_status.delete();
            errors = 0;
        end
        else
        begin
            // track register writes
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_MIN_SAMPLES: min_samples = pwdata[MIN_W-1:0];
                    REG_HR_FLOOR:    hr_floor = pwdata[HR_W-1:0];
                    REG_HRV_FLOOR:   hrv_floor = pwdata[HRV_W-1:0];
                    REG_TEMP_FLOOR:  temp_floor = pwdata[TEMP_W-1:0];
                    REG_HR_WEIGHT:   hr_wt = pwdata[WEIGHT_W-1:0];
                    REG_HRV_WEIGHT:  hrv_wt = pwdata[WEIGHT_W-1:0];
                    REG_TEMP_WEIGHT: temp_wt = pwdata[WEIGHT_W-1:0];
                    REG_FULL_SCALE:  full_scale = pwdata[FS_W-1:0];
                    default: ;
                endcase
            end

            // apply the request and predict its result
            if (in_valid && in_ready)
            begin
                if (operation == OP_ADD)
                begin
                    if (n_samples < COUNT_FULL)
                    begin
                        acc_hr = acc_hr + 64'(heart_rate);
                        acc_hrv = acc_hrv + 64'(hrv_value);
                        acc_temp = acc_temp + 64'(skin_temp);
                        n_samples = n_samples + 1;
                    end
                end
                else if (operation == OP_DAY)
                    close_day(day_number);
                else if (operation == OP_CLEAR)
                    clear_all();
                pending_status.push_back(current_status());
            end

            // compare the result with the oldest prediction
            if (out_valid && out_ready)
            begin
                got.score = score;
                got.days = days_collected;
                got.ready = baseline_ready;
                if (pending_status.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%t: unexpected result score=%0d days=%0d ready=%0d",
                                 $realtime, score, days_collected, baseline_ready);
                end
                else
                begin
                    want = pending_status.pop_front();
                    if (got != want)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"%t: mismatch exp score=%0d days=%0d ready=%0d,",
                                      " got score=%0d days=%0d ready=%0d"},
                                     $realtime, want.score, want.days, want.ready,
                                     got.score, got.days, got.ready);
                    end
                end
            end
        end
    end

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top - testbench of the baseline deviation scorer
// Drives directed and random vital-sign requests and register settings into
// the core, stalls both channels at random and leaves all checking to the
// scoreboard beside the core and to the checker bound into the core.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import bds_pkg::*;

    localparam int DAYS   = 16;
    localparam int DAYS_W = $clog2(DAYS + 1);

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                in_valid = 1'b0, in_ready;
    logic [OP_W-1:0]     operation = OP_ADD;
    logic [HR_W-1:0]     heart_rate = '0;
    logic [HRV_W-1:0]    hrv_value = '0;
    logic [TEMP_W-1:0]   skin_temp = '0;
    logic [DAY_W-1:0]    day_number = '0;
    logic                out_valid, out_ready = 1'b0;
    logic [SCORE_W-1:0]  score;
    logic [DAYS_W-1:0]   days_collected;
    logic                baseline_ready;
    int                  errors, pending;
    logic                calm = 1'b0;
    logic [DAY_W-1:0]    day_id = 32'd0;

    always #1 clk = ~clk;

    baseline_deviation_scorer_core #(.BASELINE_DAYS(DAYS), .COUNT_BITS(20)) DUT (.*);

    bds_scoreboard #(.DAYS(DAYS), .CNT_W(20), .DAYS_W(DAYS_W)) u_checker (.*);

    // random stall on the result side
    always @(posedge clk)
        out_ready <= calm || ($urandom_range(99) >= 17);

    function automatic int clip(input int v, input int hi);
        return (v < 0) ? 0 : (v > hi) ? hi : v;
    endfunction

    // issue one request, hold it until accepted
    task automatic put(input logic [OP_W-1:0] op, input int hr, input int hrv, input int tmp,
                       input logic [DAY_W-1:0] day);
        if (!calm && $urandom_range(99) < 17)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        heart_rate <= HR_W'(hr);
        hrv_value <= HRV_W'(hrv);
        skin_temp <= TEMP_W'(tmp);
        day_number <= day;
        do @(posedge clk); while (!in_ready);
    endtask

    // drain all results, then let the core go idle
    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int unsigned value, input int w);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(idx * 4);
        // random upper bits must be ignored
        pwdata <= (w < 32) ? ((($urandom & 1) ? $urandom : 0) << w) | value : value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input int mn, input int fh, input int fv, input int ft,
                             input int wh, input int wv, input int wt, input int fs);
        settle();
        write_reg(REG_MIN_SAMPLES, mn, MIN_W);
        write_reg(REG_HR_FLOOR, fh, HR_W);
        write_reg(REG_HRV_FLOOR, fv, HRV_W);
        write_reg(REG_TEMP_FLOOR, ft, TEMP_W);
        write_reg(REG_HR_WEIGHT, wh, WEIGHT_W);
        write_reg(REG_HRV_WEIGHT, wv, WEIGHT_W);
        write_reg(REG_TEMP_WEIGHT, wt, WEIGHT_W);
        write_reg(REG_FULL_SCALE, fs, FS_W);
    endtask

    // days of samples around a drifting baseline, with noise and odd requests
    task automatic run_days(input int total, input int spread);
        int hr0, hrv0, t0, hr1, hrv1, t1, left, k, pick;
        hr0 = $urandom_range(800, 2400);
        hrv0 = $urandom_range(300, 2000);
        t0 = $urandom_range(8000, 9500);
        left = total;
        while (left > 0)
        begin
            hr1 = clip(hr0 + $urandom_range(0, 2 * spread) - spread, 4095);
            hrv1 = clip(hrv0 + $urandom_range(0, 2 * spread) - spread, 8191);
            t1 = clip(t0 + $urandom_range(0, 2 * spread) - spread, 12799);
            k = $urandom_range(1, 5);
            for (int i = 0; i < k && left > 0; i++)
            begin
                pick = $urandom_range(99);
                if (pick < 8)
                    put(OP_ADD, $urandom_range(4095), $urandom_range(8191),
                        $urandom_range(12799), $urandom);
                else if (pick < 11)
                    put(OP_DAY, 0, 0, 0, day_id);
                else if (pick < 13)
                    put(2'd3, $urandom_range(4095), $urandom_range(8191),
                        $urandom_range(12799), $urandom);
                else if (pick < 14 && $urandom_range(9) == 0)
                begin
                    put(OP_CLEAR, 0, 0, 0, 0);
                    day_id = 0;
                end
                else
                    put(OP_ADD, clip(hr1 + $urandom_range(0, 4 * spread) - 2 * spread, 4095),
                        clip(hrv1 + $urandom_range(0, 4 * spread) - 2 * spread, 8191),
                        clip(t1 + $urandom_range(0, 4 * spread) - 2 * spread, 12799), $urandom);
                left--;
            end
            day_id = day_id + $urandom_range(1, 3);
            put(OP_DAY, 0, 0, 0, day_id);
            left--;
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: empty state, same-day marker, unknown operation, extremes
        put(2'd3, 4095, 8191, 12799, 32'hFFFF_FFFF);
        put(OP_DAY, 0, 0, 0, 32'd0);
        put(OP_CLEAR, 0, 0, 0, 0);
        put(OP_ADD, 0, 0, 0, 0);
        put(OP_ADD, 4095, 8191, 12799, 32'hFFFF_FFFF);
        put(OP_ADD, 12'hAAA, 13'h0AAA, 14'h2AAA, 32'h5555_5555);
        put(OP_ADD, 12'h555, 13'h1555, 14'h1555, 32'hAAAA_AAAA);
        put(OP_DAY, 0, 0, 0, 32'hFFFF_FFFF);
        put(OP_DAY, 0, 0, 0, 32'h0000_0001);
        put(OP_CLEAR, 0, 0, 0, 0);

        // zero minimum acts as one; fill the ring with single-sample days
        configure(0, 0, 0, 0, 255, 255, 255, 0);
        for (int d = 1; d <= 17; d++)
        begin
            put(OP_ADD, (d % 2) ? 4095 : 0, (d % 2) ? 8191 : 0, (d % 2) ? 12799 : 0, 0);
            put(OP_DAY, 0, 0, 0, 32'(d));
        end
        put(OP_ADD, 2000, 4000, 6000, 0);
        put(OP_DAY, 0, 0, 0, 32'd17);
        put(OP_CLEAR, 0, 0, 0, 0);
        day_id = 0;

        // random phases over several settings
        configure(2, 1, 1, 1, 255, 255, 255, 1);
        run_days(200, 30);
        calm = 1'b1;
        configure(1, 4095, 8191, 12799, 0, 0, 255, 255);
        run_days(200, 600);
        calm = 1'b0;
        configure(65535, 40, 64, 64, 77, 115, 64, 32);
        run_days(60, 40);
        configure(3, 40, 64, 64, 77, 115, 64, 32);
        run_days(220, 40);
        for (int p = 0; p < 3; p++)
        begin
            configure($urandom_range(1, 3), $urandom_range(1, 200), $urandom_range(1, 300),
                      $urandom_range(1, 300), $urandom_range(255), $urandom_range(255),
                      $urandom_range(255), $urandom_range(1, 255));
            run_days(230, $urandom_range(5, 200));
        end

        settle();
        if (errors == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

endmodule

/* filelist.f */
src/bds_pkg.sv
src/bds_lane.sv
src/bds_merge.sv
src/baseline_deviation_scorer_core.sv
src/bds_checker.sv
test/bds_checker.sv
test/tb_top.sv
